// ----- rtl/core/bounded_byte_stream_fifo_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`define BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH

// same-cycle implication
`define BBSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbsf assertion failed");

// next-cycle implication
`define BBSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbsf assertion failed");

`endif

// ----- rtl/core/bbsf_pkg.sv -----
// ---------------------------------------------------------------------------
// bbsf_pkg
// Types and constants of the bounded byte stream FIFO.
// ---------------------------------------------------------------------------
package bbsf_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = ADDR_W + 1;
  localparam int CNT_W       = 13;
  localparam int CMP_W       = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam int TOT_W       = 64;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLOSE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic rd_head;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic             push_accepted;
    logic [CNT_W-1:0] popped_amount;
    logic [7:0]       head_byte;
    logic             head_valid;
    logic [CNT_W-1:0] buffered_count;
    logic [CNT_W-1:0] free_space;
    logic [TOT_W-1:0] total_pushed;
    logic [TOT_W-1:0] total_popped;
    logic             is_closed_flag;
    logic             is_finished_flag;
  } res_t;

endpackage

// ----- rtl/core/bbsf_in_if.sv -----
// ---------------------------------------------------------------------------
// bbsf_in_if
// Request channel: push, pop or close.
// ---------------------------------------------------------------------------
interface bbsf_in_if
  import bbsf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [7:0]       push_byte;
  logic [CNT_W-1:0] pop_length;

  modport source (output valid, req_type, push_byte, pop_length, input ready);
  modport sink   (input valid, req_type, push_byte, pop_length, output ready);
endinterface

// ----- rtl/core/bbsf_out_if.sv -----
// ---------------------------------------------------------------------------
// bbsf_out_if
// Status channel, one transaction per request.
// ---------------------------------------------------------------------------
interface bbsf_out_if
  import bbsf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             push_accepted;
  logic [CNT_W-1:0] popped_amount;
  logic [7:0]       head_byte;
  logic             head_valid;
  logic [CNT_W-1:0] buffered_count;
  logic [CNT_W-1:0] free_space;
  logic [TOT_W-1:0] total_pushed;
  logic [TOT_W-1:0] total_popped;
  logic             is_closed_flag;
  logic             is_finished_flag;

  modport source (output valid, push_accepted, popped_amount, head_byte, head_valid,
                  buffered_count, free_space, total_pushed, total_popped,
                  is_closed_flag, is_finished_flag, input ready);
  modport sink   (input valid, push_accepted, popped_amount, head_byte, head_valid,
                  buffered_count, free_space, total_pushed, total_popped,
                  is_closed_flag, is_finished_flag, output ready);
endinterface

// ----- rtl/core/bbsf_cfg_if.sv -----
// ---------------------------------------------------------------------------
// bbsf_cfg_if
// Capacity register write channel.
// ---------------------------------------------------------------------------
interface bbsf_cfg_if
  import bbsf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/bounded_byte_stream_fifo.sv -----
// ---------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Capacity-limited byte stream FIFO with close, one status result per request.
// ---------------------------------------------------------------------------
//  port   dir  carries
//  in_i   in   req_type, push_byte, pop_length
//  out_o  out  push/pop outcome, head byte, counts, totals, close flags
//  cfg_i  in   capacity_limit write data
//
//  A request passes through accept, state update and store write, head read
//  from the single-port-read byte store, and result register load.
//  The next request is accepted while the previous result waits in out_o.
//  A stalled result holds the sequencer in its last step until taken.
//  Reset clears pointers, counters and flags at once; the store is not cleared.
// ---------------------------------------------------------------------------
`include "bounded_byte_stream_fifo_assert.svh"

module bounded_byte_stream_fifo
  import bbsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bbsf_in_if.sink    in_i,
  bbsf_out_if.source out_o,
  bbsf_cfg_if.sink   cfg_i
);
  cmd_t cmd;
  res_t res;

  assign cfg_i.ready = 1'b1;

  bbsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  bbsf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (in_i.req_type),
    .push_byte_i (in_i.push_byte),
    .pop_length_i(in_i.pop_length),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .res_o       (res)
  );

  assign out_o.push_accepted    = res.push_accepted;
  assign out_o.popped_amount    = res.popped_amount;
  assign out_o.head_byte        = res.head_byte;
  assign out_o.head_valid       = res.head_valid;
  assign out_o.buffered_count   = res.buffered_count;
  assign out_o.free_space       = res.free_space;
  assign out_o.total_pushed     = res.total_pushed;
  assign out_o.total_popped     = res.total_popped;
  assign out_o.is_closed_flag   = res.is_closed_flag;
  assign out_o.is_finished_flag = res.is_finished_flag;

  `BBSF_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready)
  `BBSF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_o.valid || out_o.ready)
  `BBSF_ASSERT_NOW(a_head_vs_count, out_o.valid, out_o.head_valid == (out_o.buffered_count != '0))
  `BBSF_ASSERT_NOW(a_fill_bound, out_o.valid, out_o.buffered_count <= CNT_W'(STORE_DEPTH))
endmodule

// ----- rtl/core/bbsf_ram.sv -----
// ---------------------------------------------------------------------------
// bbsf_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/bbsf_datapath.sv -----
// ---------------------------------------------------------------------------
// bbsf_datapath
// Pointers, counters, byte store and result register.
// ---------------------------------------------------------------------------
module bbsf_datapath
  import bbsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       push_byte_i,
  input  logic [CNT_W-1:0] pop_length_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  output res_t             res_o
);
  logic [1:0]        req_q;
  logic [7:0]        byte_q;
  logic [CNT_W-1:0]  len_q;
  logic [CNT_W-1:0]  cap_q;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [TOT_W-1:0]  pushed_q, pushed_d;
  logic [TOT_W-1:0]  popped_q, popped_d;
  logic              closed_q, closed_d;
  logic              acc_q, acc_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  res_t              res_q;

  logic [CMP_W-1:0]  cap_eff, fill_ext, want_ext;
  logic              push_ok, ram_we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        ram_rdata;

  assign fill_ext = CMP_W'(fill_q);
  assign want_ext = CMP_W'(len_q);
  assign cap_eff  = (CMP_W'(cap_q) > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH)
                                                          : CMP_W'(cap_q);
  assign push_ok  = (req_q == REQ_PUSH) && (fill_ext < cap_eff);
  assign waddr    = rp_q + ADDR_W'(fill_q);
  assign ram_we   = cmd_i.exec && push_ok;

  always_comb begin
    rp_d     = rp_q;
    fill_d   = fill_q;
    pushed_d = pushed_q;
    popped_d = popped_q;
    closed_d = closed_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    if (cmd_i.exec) begin
      acc_d = 1'b0;
      rem_d = '0;
      case (req_q)
        REQ_PUSH: begin
          if (push_ok) begin
            acc_d    = 1'b1;
            fill_d   = fill_q + FILL_W'(1);
            pushed_d = pushed_q + TOT_W'(1);
          end
        end
        REQ_POP: begin
          rem_d    = (want_ext < fill_ext) ? FILL_W'(want_ext) : fill_q;
          rp_d     = rp_q + ADDR_W'(rem_d);
          fill_d   = fill_q - rem_d;
          popped_d = popped_q + TOT_W'(rem_d);
        end
        REQ_CLOSE: closed_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      fill_q   <= '0;
      pushed_q <= '0;
      popped_q <= '0;
      closed_q <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      rp_q     <= rp_d;
      fill_q   <= fill_d;
      pushed_q <= pushed_d;
      popped_q <= popped_d;
      closed_q <= closed_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q  <= req_type_i;
      byte_q <= push_byte_i;
      len_q  <= pop_length_i;
    end
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (cmd_i.load_out) begin
      res_q.push_accepted    <= acc_q;
      res_q.popped_amount    <= CNT_W'(rem_q);
      res_q.head_byte        <= (fill_q != '0) ? ram_rdata : 8'd0;
      res_q.head_valid       <= (fill_q != '0);
      res_q.buffered_count   <= CNT_W'(fill_q);
      res_q.free_space       <= (cap_eff > fill_ext) ? CNT_W'(cap_eff - fill_ext) : '0;
      res_q.total_pushed     <= pushed_q;
      res_q.total_popped     <= popped_q;
      res_q.is_closed_flag   <= closed_q;
      res_q.is_finished_flag <= closed_q && (fill_q == '0);
    end
  end

  bbsf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(byte_q),
    .re_i   (cmd_i.rd_head),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  assign res_o = res_q;
endmodule

// ----- rtl/core/bbsf_ctrl.sv -----
// ---------------------------------------------------------------------------
// bbsf_ctrl
// Request sequencer and result valid flag.
// ---------------------------------------------------------------------------
module bbsf_ctrl
  import bbsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_READ;
      ST_READ: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_EXEC: cmd_o.exec     = 1'b1;
      ST_READ: cmd_o.rd_head  = 1'b1;
      ST_DONE: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
